FILE: sv/bffa_pkg.sv
package bffa_pkg;

  // Map capacities and word geometry.
  localparam int DATA_BITS_MAX  = 8192;
  localparam int INODE_BITS_MAX = 1024;
  localparam int MAP_WORD_BITS  = 64;

  localparam int DATA_WORDS  = (DATA_BITS_MAX + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int INODE_WORDS = (INODE_BITS_MAX + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int DATA_AW     = $clog2(DATA_WORDS);
  localparam int INODE_AW    = $clog2(INODE_WORDS);
  localparam int BIT_W       = $clog2(MAP_WORD_BITS);

  // A limit holds any count up to the data capacity itself.
  localparam int LIM_W    = $clog2(DATA_BITS_MAX) + 1;
  localparam int LIM_HI_W = LIM_W - BIT_W;

  // Register widths.
  localparam int BASE_W = 32;
  localparam int DCNT_W = 14;
  localparam int ICNT_W = 11;
  localparam int REG_AW = 2;

  // Register indexes.
  localparam logic [REG_AW-1:0] REG_DATA_BASE   = 2'd0;
  localparam logic [REG_AW-1:0] REG_DATA_COUNT  = 2'd1;
  localparam logic [REG_AW-1:0] REG_INODE_COUNT = 2'd2;

  // Commands.
  localparam logic [1:0] CMD_ALLOC_DATA  = 2'd0;
  localparam logic [1:0] CMD_ALLOC_INODE = 2'd1;
  localparam logic [1:0] CMD_FREE_DATA   = 2'd2;
  localparam logic [1:0] CMD_FREE_INODE  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Result of the free-bit search over one map word.
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_t;

endpackage

FILE: sv/bffa_ram.sv
module bffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bffa_find.sv
module bffa_find (
  input  logic [bffa_pkg::MAP_WORD_BITS-1:0] word,
  input  logic [bffa_pkg::DATA_AW-1:0]       wsel,
  input  logic [bffa_pkg::LIM_W-1:0]         limit,
  output bffa_pkg::find_t                    res
);

  // Bits at or above the limit count as taken; the lowest free bit wins.
  always_comb begin
    logic [bffa_pkg::LIM_HI_W-1:0]      wext;
    logic [bffa_pkg::MAP_WORD_BITS-1:0] mask;
    logic [bffa_pkg::MAP_WORD_BITS-1:0] avail;
    wext = bffa_pkg::LIM_HI_W'(wsel);
    if (wext < limit[bffa_pkg::LIM_W-1:bffa_pkg::BIT_W]) begin
      mask = '1;
    end else if (wext == limit[bffa_pkg::LIM_W-1:bffa_pkg::BIT_W]) begin
      mask = (bffa_pkg::MAP_WORD_BITS'(1) << limit[bffa_pkg::BIT_W-1:0])
             - bffa_pkg::MAP_WORD_BITS'(1);
    end else begin
      mask = '0;
    end
    avail = ~word & mask;
    res.found = |avail;
    res.bit_idx = '0;
    for (int b = bffa_pkg::MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res.bit_idx = bffa_pkg::BIT_W'(b);
      end
    end
  end

endmodule

FILE: sv/bitmap_first_free_allocator.sv
// Allocate: take the request, then one map word per cycle through the single word
// search unit (up to 128 words), one write and one output step; a full map skips the
// write. Free: take, check and read, write back (skipped when out of range), output.
// One request is in work at a time; the next is taken as soon as the result is
// registered. Synchronous reset clears both maps at once through per-word valid
// bits and loads data_base 0, data_count 8192, inode_count 1024.
module bitmap_first_free_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [39:0]                  s_tdata,   // [1:0] command, [33:2] number
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [39:0]                  m_tdata,   // [31:0] index, [33:32] status
  input  logic                         cfg_we,
  input  logic [bffa_pkg::REG_AW-1:0]  cfg_addr,
  input  logic [bffa_pkg::BASE_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FCHK,
    S_FWR,
    S_DONE
  } state_t;

  state_t                              state;
  logic [bffa_pkg::BASE_W-1:0]         data_base;
  logic [bffa_pkg::DCNT_W-1:0]         data_count;
  logic [bffa_pkg::ICNT_W-1:0]         inode_count;
  logic [1:0]                          cmd_r;
  logic [31:0]                         off_r;
  logic [bffa_pkg::LIM_W-1:0]          limit_r;
  logic [bffa_pkg::DATA_AW-1:0]        last_w;
  logic [bffa_pkg::DATA_AW-1:0]        rd_ptr;
  logic [bffa_pkg::DATA_AW-1:0]        chk_ptr;
  logic                                chk_v;
  logic                                vld_q;
  logic [bffa_pkg::MAP_WORD_BITS-1:0]  word_r;
  logic [bffa_pkg::DATA_AW-1:0]        fnd_w;
  logic [bffa_pkg::BIT_W-1:0]          fnd_bit;
  logic [31:0]                         res_index;
  bffa_pkg::status_t                   res_status;
  logic [31:0]                         m_index;
  bffa_pkg::status_t                   m_status;
  logic [bffa_pkg::DATA_WORDS-1:0]     data_vld;
  logic [bffa_pkg::INODE_WORDS-1:0]    inode_vld;

  logic [1:0]                          s_cmd;
  logic [31:0]                         s_num;
  logic [bffa_pkg::LIM_W-1:0]          d_lim;
  logic [bffa_pkg::LIM_W-1:0]          i_lim;
  logic [bffa_pkg::LIM_W-1:0]          lim_in;
  logic [bffa_pkg::LIM_W-1:0]          lim_m1;
  logic [bffa_pkg::DATA_AW-1:0]        ram_raddr;
  logic [bffa_pkg::MAP_WORD_BITS-1:0]  d_rdata;
  logic [bffa_pkg::MAP_WORD_BITS-1:0]  i_rdata;
  logic [bffa_pkg::MAP_WORD_BITS-1:0]  rword;
  logic [bffa_pkg::MAP_WORD_BITS-1:0]  clr_word;
  logic                                map_we;
  logic [bffa_pkg::DATA_AW-1:0]        map_waddr;
  logic [bffa_pkg::MAP_WORD_BITS-1:0]  map_wdata;
  logic                                d_we;
  logic                                i_we;
  logic                                vld_sel;
  bffa_pkg::find_t                     fnd;

  // Request fields and effective limits, capped at the map capacities.
  assign s_cmd  = s_tdata[1:0];
  assign s_num  = s_tdata[33:2];
  assign d_lim  = (data_count > bffa_pkg::DCNT_W'(bffa_pkg::DATA_BITS_MAX))
                  ? bffa_pkg::LIM_W'(bffa_pkg::DATA_BITS_MAX)
                  : bffa_pkg::LIM_W'(data_count);
  assign i_lim  = (inode_count > bffa_pkg::ICNT_W'(bffa_pkg::INODE_BITS_MAX))
                  ? bffa_pkg::LIM_W'(bffa_pkg::INODE_BITS_MAX)
                  : bffa_pkg::LIM_W'(inode_count);
  assign lim_in = s_cmd[0] ? i_lim : d_lim;
  assign lim_m1 = lim_in - bffa_pkg::LIM_W'(1);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {6'b0, m_status, m_index};

  // Read address: the scan pointer, or the word that a free touches.
  assign ram_raddr = (state == S_FCHK) ? off_r[bffa_pkg::BIT_W +: bffa_pkg::DATA_AW]
                                       : rd_ptr;
  assign vld_sel   = cmd_r[0] ? inode_vld[ram_raddr[bffa_pkg::INODE_AW-1:0]]
                              : data_vld[ram_raddr];

  // A word never written reads as all free.
  assign rword    = vld_q ? (cmd_r[0] ? i_rdata : d_rdata) : '0;
  assign clr_word = rword & ~(bffa_pkg::MAP_WORD_BITS'(1) << off_r[bffa_pkg::BIT_W-1:0]);

  // Write back: the word with the found bit set, or with the freed bit cleared.
  assign map_we    = (state == S_WRITE) || (state == S_FWR);
  assign map_waddr = (state == S_WRITE) ? fnd_w : off_r[bffa_pkg::BIT_W +: bffa_pkg::DATA_AW];
  assign map_wdata = (state == S_WRITE) ? word_r : clr_word;
  assign d_we      = map_we && !cmd_r[0];
  assign i_we      = map_we && cmd_r[0];

  bffa_ram #(
    .WIDTH (bffa_pkg::MAP_WORD_BITS),
    .DEPTH (bffa_pkg::DATA_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (ram_raddr),
    .rdata (d_rdata)
  );

  bffa_ram #(
    .WIDTH (bffa_pkg::MAP_WORD_BITS),
    .DEPTH (bffa_pkg::INODE_WORDS)
  ) u_inode_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (map_waddr[bffa_pkg::INODE_AW-1:0]),
    .wdata (map_wdata),
    .raddr (ram_raddr[bffa_pkg::INODE_AW-1:0]),
    .rdata (i_rdata)
  );

  bffa_find u_find (
    .word  (rword),
    .wsel  (chk_ptr),
    .limit (limit_r),
    .res   (fnd)
  );

  // Sequencer, configuration registers, valid bits and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      data_base   <= '0;
      data_count  <= bffa_pkg::DCNT_W'(bffa_pkg::DATA_BITS_MAX);
      inode_count <= bffa_pkg::ICNT_W'(bffa_pkg::INODE_BITS_MAX);
      chk_v       <= 1'b0;
      m_tvalid    <= 1'b0;
      data_vld    <= '0;
      inode_vld   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          bffa_pkg::REG_DATA_BASE:   data_base   <= cfg_wdata;
          bffa_pkg::REG_DATA_COUNT:  data_count  <= cfg_wdata[bffa_pkg::DCNT_W-1:0];
          bffa_pkg::REG_INODE_COUNT: inode_count <= cfg_wdata[bffa_pkg::ICNT_W-1:0];
          default: ;
        endcase
      end

      if (d_we) begin
        data_vld[map_waddr] <= 1'b1;
      end
      if (i_we) begin
        inode_vld[map_waddr[bffa_pkg::INODE_AW-1:0]] <= 1'b1;
      end

      vld_q <= vld_sel;

      // The result state reloads the output register itself.
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r      <= s_cmd;
            off_r      <= (s_cmd == bffa_pkg::CMD_FREE_DATA) ? s_num - data_base : s_num;
            limit_r    <= lim_in;
            last_w     <= lim_m1[bffa_pkg::BIT_W +: bffa_pkg::DATA_AW];
            rd_ptr     <= '0;
            chk_v      <= 1'b0;
            res_index  <= '0;
            res_status <= (!s_cmd[1] && (lim_in == '0)) ? bffa_pkg::ST_FULL
                                                        : bffa_pkg::ST_OK;
            if (s_cmd[1]) begin
              state <= S_FCHK;
            end else if (lim_in == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        // Reads run one word ahead of the search.
        S_SCAN: begin
          rd_ptr  <= rd_ptr + 1'b1;
          chk_ptr <= rd_ptr;
          chk_v   <= 1'b1;
          if (chk_v) begin
            if (fnd.found) begin
              word_r  <= rword | (bffa_pkg::MAP_WORD_BITS'(1) << fnd.bit_idx);
              fnd_w   <= chk_ptr;
              fnd_bit <= fnd.bit_idx;
              state   <= S_WRITE;
            end else if (chk_ptr == last_w) begin
              res_status <= bffa_pkg::ST_FULL;
              state      <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          if (cmd_r[0]) begin
            res_index <= 32'({fnd_w, fnd_bit});
          end else begin
            res_index <= data_base + 32'({fnd_w, fnd_bit});
          end
          state <= S_DONE;
        end
        S_FCHK: begin
          if (off_r >= 32'(limit_r)) begin
            res_status <= bffa_pkg::ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_FWR;
          end
        end
        S_FWR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_index  <= res_index;
            m_status <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The checked word is always the one read in the cycle before.
  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && chk_v |-> rd_ptr == chk_ptr + 1'b1)
    else $error("scan pointers out of step");

  // Full and out-of-range results carry a zero index.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_status != bffa_pkg::ST_OK) |-> m_index == '0)
    else $error("failed request returned a nonzero index");

  // A taken request starts a scan, a free check or goes straight to the result.
  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == S_SCAN) || (state == S_FCHK) || (state == S_DONE))
    else $error("accepted request did not start");

  // A map word is set only after a successful search.
  a_write_from_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $past(state) == S_SCAN)
    else $error("allocation write without a search");

endmodule

FILE: tb/tb_top.sv
module tb_top;

  // One reply of the allocator.
  typedef struct packed {
    logic [31:0]       index;
    bffa_pkg::status_t status;
  } reply_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [39:0]                   s_tdata = '0;   // [1:0] command, [33:2] number
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [39:0]                   m_tdata;        // [31:0] index, [33:32] status
  logic                          cfg_we = 1'b0;
  logic [bffa_pkg::REG_AW-1:0]   cfg_addr = '0;
  logic [bffa_pkg::BASE_W-1:0]   cfg_wdata = '0;

  // Requests waiting to be sent, and replies the allocator still owes.
  logic [39:0] cmd_q[$];
  reply_t      reply_q[$];
  reply_t      want;
  int          errors = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  // Shadow of the configuration registers and of both allocation maps.
  logic [31:0]                         base_reg = '0;
  logic [bffa_pkg::DCNT_W-1:0]         dcount_reg = 14'd8192;
  logic [bffa_pkg::ICNT_W-1:0]         icount_reg = 11'd1024;
  logic [bffa_pkg::DATA_BITS_MAX-1:0]  data_used = '0;
  logic [bffa_pkg::INODE_BITS_MAX-1:0] inode_used = '0;

  bitmap_first_free_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow maps and return the reply it produces.
  function automatic reply_t compute_reply(input logic [1:0] op, input logic [31:0] num);
    reply_t      r;
    int          dlim;
    int          ilim;
    logic [31:0] off;
    r.index = '0;
    r.status = bffa_pkg::ST_OK;
    // Counts above the map capacity behave as the capacity.
    dlim = (dcount_reg > bffa_pkg::DATA_BITS_MAX) ? bffa_pkg::DATA_BITS_MAX
                                                  : int'(dcount_reg);
    ilim = (icount_reg > bffa_pkg::INODE_BITS_MAX) ? bffa_pkg::INODE_BITS_MAX
                                                   : int'(icount_reg);
    case (op)
      bffa_pkg::CMD_ALLOC_DATA: begin
        r.status = bffa_pkg::ST_FULL;
        for (int i = 0; i < dlim && r.status == bffa_pkg::ST_FULL; i++) begin
          if (!data_used[i]) begin
            data_used[i] = 1'b1;
            r.index = base_reg + i;
            r.status = bffa_pkg::ST_OK;
          end
        end
      end
      bffa_pkg::CMD_ALLOC_INODE: begin
        r.status = bffa_pkg::ST_FULL;
        for (int i = 0; i < ilim && r.status == bffa_pkg::ST_FULL; i++) begin
          if (!inode_used[i]) begin
            inode_used[i] = 1'b1;
            r.index = i;
            r.status = bffa_pkg::ST_OK;
          end
        end
      end
      bffa_pkg::CMD_FREE_DATA: begin
        off = num - base_reg;
        if (off < dlim) begin
          data_used[off[12:0]] = 1'b0;
        end else begin
          r.status = bffa_pkg::ST_RANGE;
        end
      end
      default: begin
        if (num < ilim) begin
          inode_used[num[9:0]] = 1'b0;
        end else begin
          r.status = bffa_pkg::ST_RANGE;
        end
      end
    endcase
    return r;
  endfunction

  // Random request: mostly allocations and frees near the allocated region,
  // with some requests of entirely random content.
  function automatic logic [39:0] random_request();
    logic [1:0]  op;
    logic [31:0] num;
    int          pick;
    int          dlim;
    int          ilim;
    dlim = (dcount_reg > bffa_pkg::DATA_BITS_MAX) ? bffa_pkg::DATA_BITS_MAX
                                                  : int'(dcount_reg);
    ilim = (icount_reg > bffa_pkg::INODE_BITS_MAX) ? bffa_pkg::INODE_BITS_MAX
                                                   : int'(icount_reg);
    pick = $urandom_range(99);
    num = $urandom();
    if (pick < 30) begin
      op = bffa_pkg::CMD_ALLOC_DATA;
    end else if (pick < 50) begin
      op = bffa_pkg::CMD_ALLOC_INODE;
    end else if (pick < 75) begin
      op = bffa_pkg::CMD_FREE_DATA;
      if ($urandom_range(3) == 0) begin
        num = base_reg + $urandom_range(dlim + 1);
      end else begin
        num = base_reg + $urandom_range((dlim < 64) ? dlim : 64);
      end
    end else if (pick < 95) begin
      op = bffa_pkg::CMD_FREE_INODE;
      num = $urandom_range(ilim + 1);
    end else begin
      op = 2'($urandom_range(3));
    end
    return {6'b0, num, op};
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [31:0] num);
    cmd_q.push_back({6'b0, num, op});
  endtask

  // Hold off new requests until every reply has come back.
  task automatic settle();
    while (cmd_q.size() != 0 || s_tvalid || reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bffa_pkg::REG_AW-1:0] addr,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    case (addr)
      bffa_pkg::REG_DATA_BASE:  base_reg = value;
      bffa_pkg::REG_DATA_COUNT: dcount_reg = value[bffa_pkg::DCNT_W-1:0];
      default:                  icount_reg = value[bffa_pkg::ICNT_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Request driver; the reply of each accepted request is worked out here.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        reply_q.push_back(compute_reply(s_tdata[1:0], s_tdata[33:2]));
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= cmd_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Reply monitor: each reply is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        $error("reply with none outstanding: index %0h, status %0d",
               m_tdata[31:0], m_tdata[33:32]);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (m_tdata[31:0] !== want.index) begin
          $error("index: expected %0h, got %0h", want.index, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[33:32] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[33:32]);
          errors++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 38;
    rx_idle_pct = 62;

    // Reset configuration: first fit, double free and frees past the map end.
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_ALLOC_INODE, $urandom());
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'd0);
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'd0);
    queue_request(bffa_pkg::CMD_ALLOC_DATA, 32'hFFFF_FFFF);
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'd8191);
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'd8192);
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'hFFFF_FFFF);
    queue_request(bffa_pkg::CMD_FREE_INODE, 32'd1023);
    queue_request(bffa_pkg::CMD_FREE_INODE, 32'd1024);
    queue_request(bffa_pkg::CMD_FREE_INODE, 32'hFFFF_FFFF);

    // Shrunk counts with a base that wraps: the low bits stay taken.
    settle();
    write_reg(bffa_pkg::REG_DATA_BASE, 32'hFFFF_FFFF);
    write_reg(bffa_pkg::REG_DATA_COUNT, 32'd3);
    write_reg(bffa_pkg::REG_INODE_COUNT, 32'd2);
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'd0);
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'hFFFF_FFFE);
    queue_request(bffa_pkg::CMD_ALLOC_INODE, $urandom());
    queue_request(bffa_pkg::CMD_ALLOC_INODE, $urandom());
    queue_request(bffa_pkg::CMD_FREE_INODE, 32'd2);

    // Zero counts: every allocation is full and every free out of range.
    settle();
    write_reg(bffa_pkg::REG_DATA_COUNT, 32'd0);
    write_reg(bffa_pkg::REG_INODE_COUNT, 32'd0);
    queue_request(bffa_pkg::CMD_ALLOC_DATA, $urandom());
    queue_request(bffa_pkg::CMD_ALLOC_INODE, $urandom());
    queue_request(bffa_pkg::CMD_FREE_DATA, 32'hFFFF_FFFF);
    queue_request(bffa_pkg::CMD_FREE_INODE, 32'd0);

    // Random traffic in three idling regimes, three settings each.
    for (int m = 0; m < 3; m++) begin
      for (int b = 0; b < 3; b++) begin
        settle();
        tx_idle_pct = (m == 0) ? 38 : (m == 1) ? 62 : 0;
        rx_idle_pct = (m == 0) ? 62 : (m == 1) ? 38 : 0;
        case (m * 3 + b)
          0:       write_reg(bffa_pkg::REG_DATA_BASE, 32'd0);
          4:       write_reg(bffa_pkg::REG_DATA_BASE, 32'hFFFF_FFFF);
          7:       write_reg(bffa_pkg::REG_DATA_BASE, 32'hFFFF_FFC0);
          default: write_reg(bffa_pkg::REG_DATA_BASE, $urandom());
        endcase
        case (m * 3 + b)
          2:       write_reg(bffa_pkg::REG_DATA_COUNT, 32'd8192);
          5:       write_reg(bffa_pkg::REG_DATA_COUNT, 32'd16383);
          8:       write_reg(bffa_pkg::REG_DATA_COUNT, 32'd0);
          default: write_reg(bffa_pkg::REG_DATA_COUNT, $urandom_range(1, 100));
        endcase
        case (m * 3 + b)
          1:       write_reg(bffa_pkg::REG_INODE_COUNT, 32'd1024);
          5:       write_reg(bffa_pkg::REG_INODE_COUNT, 32'd2047);
          6:       write_reg(bffa_pkg::REG_INODE_COUNT, 32'd0);
          default: write_reg(bffa_pkg::REG_INODE_COUNT, $urandom_range(1, 40));
        endcase
        repeat (145) cmd_q.push_back(random_request());
      end
    end

    settle();
    repeat (140) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
sv/bffa_pkg.sv
sv/bffa_ram.sv
sv/bffa_find.sv
sv/bitmap_first_free_allocator.sv
tb/tb_top.sv
